/* hdl/at2_pkg.sv */
`default_nettype none

package at2_pkg;

  // Fixed-point working format of the polynomial
  localparam int Q_BITS = 30;

  // Default configuration of the top level
  localparam int DEF_RATIO_FRAC_BITS = 24;
  localparam int DEF_ANGLE_FRAC_BITS = 29;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  // Q30 polynomial coefficients, lowest order first
  localparam logic signed [32:0] COEF [5] = '{
    33'sd1073597943, -33'sd354656388, 33'sd193424926, -33'sd91410863, 33'sd22371518
  };

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Classification of one item, as handed from front to back
  typedef struct packed {
    logic [31:0] mn;
    logic [31:0] mx;
    logic        swap;
    logic        xneg;
    logic        yneg;
    logic        xzero;
    logic        yzero;
  } at2_item_t;

  // Signed Q30 times a nonnegative Q30 value, truncated toward zero
  function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
                                                 input logic [30:0] b);
    logic [32:0] m;
    logic [63:0] p;
    logic [32:0] s;
    begin
      m = a[32] ? 33'(-a) : 33'(a);
      p = 64'(m) * 64'(b);
      s = p[62:30];
      mul_q30 = a[32] ? $signed(33'(-s)) : $signed(s);
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/at2_front.sv */
`default_nettype none

module at2_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [31:0]       y_value,
  input  wire logic [31:0]       x_value,
  output logic                   push,
  output at2_pkg::at2_item_t     push_item,
  input  wire logic              queue_full
);
  import at2_pkg::*;

  logic      hold_valid;
  at2_item_t hold_item;
  at2_item_t item_next;
  logic [31:0] ay;
  logic [31:0] ax;

  // Take magnitudes and order them
  always_comb begin
    ay = y_value[31] ? 32'(-y_value) : y_value;
    ax = x_value[31] ? 32'(-x_value) : x_value;
    item_next.swap  = ay > ax;
    item_next.mn    = (ay > ax) ? ax : ay;
    item_next.mx    = (ay > ax) ? ay : ax;
    item_next.xneg  = x_value[31];
    item_next.yneg  = y_value[31];
    item_next.xzero = ax == 32'd0;
    item_next.yzero = ay == 32'd0;
  end

  assign req_stall = hold_valid && queue_full;
  assign push      = hold_valid && !queue_full;
  assign push_item = hold_item;

  // Load a new item whenever the holding register drains
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
    if (!req_stall && req_valid) begin
      hold_item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/at2_queue.sv */
`default_nettype none

module at2_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  at2_pkg::at2_item_t     push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output at2_pkg::at2_item_t     head
);
  import at2_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  at2_item_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/at2_back.sv */
`default_nettype none

module at2_back #(
  parameter int RATIO_FRAC_BITS = at2_pkg::DEF_RATIO_FRAC_BITS,
  parameter int ANGLE_FRAC_BITS = at2_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  at2_pkg::at2_item_t     head,
  output logic                   pop,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [31:0]            angle
);
  import at2_pkg::*;

  localparam int QW   = RATIO_FRAC_BITS + 1;
  localparam int DIVS = RATIO_FRAC_BITS + 1;
  localparam int POLS = 6;

  logic advance;

  // Divider stages: one quotient bit each
  logic            dv_valid [DIVS];
  at2_item_t       dv_item  [DIVS];
  logic [31:0]     dv_rem   [DIVS];
  logic [QW-1:0]   dv_q     [DIVS];

  // Polynomial stages
  logic                   ps_valid [POLS];
  at2_item_t              ps_item  [POLS];
  logic [30:0]            ps_r     [POLS];
  logic [30:0]            ps_t     [POLS];
  logic signed [32:0]     ps_acc   [POLS];

  logic [30:0] r_q30;
  logic [61:0] r_sq;

  assign advance = !res_valid || !res_stall;
  assign pop     = advance && head_valid;

  genvar k;
  generate
    for (k = 0; k < DIVS; k++) begin : g_div
      logic [32:0]   cand;
      logic          ge;
      logic [32:0]   diff;
      at2_item_t     src_item;
      logic          src_valid;
      logic [QW-1:0] src_q;

      if (k == 0) begin : g_first
        assign cand      = {1'b0, head.mn};
        assign src_item  = head;
        assign src_valid = head_valid;
        assign src_q     = '0;
      end else begin : g_rest
        assign cand      = {dv_rem[k-1], 1'b0};
        assign src_item  = dv_item[k-1];
        assign src_valid = dv_valid[k-1];
        assign src_q     = dv_q[k-1];
      end

      // Compare and subtract the divisor
      assign ge   = cand >= {1'b0, src_item.mx};
      assign diff = cand - {1'b0, src_item.mx};

      always_ff @(posedge clk) begin
        if (rst) begin
          dv_valid[k] <= 1'b0;
        end else if (advance) begin
          dv_valid[k] <= src_valid;
        end
        if (advance) begin
          dv_item[k] <= src_item;
          dv_rem[k]  <= ge ? diff[31:0] : cand[31:0];
          if (QW > 1) begin
            dv_q[k] <= {src_q[QW-2:0], ge};
          end else begin
            dv_q[k] <= QW'(ge);
          end
        end
      end
    end
  endgenerate

  // Move the quotient to Q30
  generate
    if (RATIO_FRAC_BITS <= Q_BITS) begin : g_up
      assign r_q30 = 31'(dv_q[DIVS-1]) << (Q_BITS - RATIO_FRAC_BITS);
    end else begin : g_down
      assign r_q30 = 31'(dv_q[DIVS-1] >> (RATIO_FRAC_BITS - Q_BITS));
    end
  endgenerate

  assign r_sq = 62'(r_q30) * 62'(r_q30);

  // First polynomial stage: square the ratio, seed the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      ps_valid[0] <= 1'b0;
    end else if (advance) begin
      ps_valid[0] <= dv_valid[DIVS-1];
    end
    if (advance) begin
      ps_item[0] <= dv_item[DIVS-1];
      ps_r[0]    <= r_q30;
      ps_t[0]    <= r_sq[60:30];
      ps_acc[0]  <= COEF[4];
    end
  end

  // Horner steps, then the final multiply by the ratio
  generate
    for (k = 1; k < POLS; k++) begin : g_poly
      logic signed [32:0] acc_next;
      if (k < POLS - 1) begin : g_horner
        assign acc_next = COEF[4-k] + mul_q30(ps_acc[k-1], ps_t[k-1]);
      end else begin : g_ratio
        assign acc_next = mul_q30(ps_acc[k-1], ps_r[k-1]);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          ps_valid[k] <= 1'b0;
        end else if (advance) begin
          ps_valid[k] <= ps_valid[k-1];
        end
        if (advance) begin
          ps_item[k] <= ps_item[k-1];
          ps_r[k]    <= ps_r[k-1];
          ps_t[k]    <= ps_t[k-1];
          ps_acc[k]  <= acc_next;
        end
      end
    end
  endgenerate

  // Reflect, move to the right quadrant and apply the sign
  at2_item_t   fin;
  logic [31:0] base;
  logic [31:0] refl;
  logic [31:0] mag;
  logic        neg;
  logic [31:0] scaled;
  logic [31:0] angle_next;

  always_comb begin
    fin  = ps_item[POLS-1];
    base = ps_acc[POLS-1][32] ? 32'd0 : ps_acc[POLS-1][31:0];
    refl = base;
    if (fin.swap) begin
      refl = (HALF_PI_Q30 > base) ? HALF_PI_Q30 - base : 32'd0;
    end
    mag = fin.xneg ? PI_Q30 - refl : refl;
    neg = fin.yneg;
    if (fin.xzero) begin
      mag = fin.yzero ? 32'd0 : HALF_PI_Q30;
      neg = fin.yzero ? 1'b0 : fin.yneg;
    end
    scaled     = mag >> (Q_BITS - ANGLE_FRAC_BITS);
    angle_next = neg ? 32'(-scaled) : scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= ps_valid[POLS-1];
    end
    if (advance) begin
      angle <= angle_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/arc_tangent_two_argument.sv */
// Four-quadrant arc tangent of (y_value, x_value), given as a signed angle in
// radians with ANGLE_FRAC_BITS fraction bits. Takes one item per cycle and
// holds that rate without stalling while res_stall is low. An item passes
// through the ratio divider, which settles one quotient bit per pipeline
// stage, then six multiply stages and the output register.
// A four-entry queue after the input register absorbs short output stalls.
`default_nettype none

module arc_tangent_two_argument #(
  parameter int RATIO_FRAC_BITS = at2_pkg::DEF_RATIO_FRAC_BITS,
  parameter int ANGLE_FRAC_BITS = at2_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [31:0] y_value,
  input  wire logic [31:0] x_value,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [31:0]      angle
);
  import at2_pkg::*;

  localparam logic [31:0] PI_OUT = PI_Q30 >> (Q_BITS - ANGLE_FRAC_BITS);

  logic      push;
  at2_item_t push_item;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  at2_item_t head;

  at2_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .y_value    (y_value),
    .x_value    (x_value),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  at2_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  at2_back #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .angle      (angle)
  );

  // Angle never leaves [-pi, pi]
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($signed(angle) <= $signed(PI_OUT) &&
                   $signed(angle) >= -$signed(PI_OUT)))
    else $error("angle out of range");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Input is held off only while an item waits in front
  a_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> $past(req_valid) || $past(req_stall))
    else $error("stall without a held item");

endmodule

`default_nettype wire

/* verif/tb_arc_tangent_two_argument.sv */
`timescale 1ns / 100ps

module tb_arc_tangent_two_argument;

  localparam int RFB = at2_pkg::DEF_RATIO_FRAC_BITS;
  localparam int AFB = at2_pkg::DEF_ANGLE_FRAC_BITS;
  localparam int NUM_RANDOM = 450;

  // Signed Q30 times nonnegative Q30, truncated toward zero
  function automatic longint q30_product(longint a, longint b);
    longint m;
    longint p;
    begin
      m = (a < 0) ? -a : a;
      p = (m * b) >>> 30;
      q30_product = (a < 0) ? -p : p;
    end
  endfunction

  // Expected angle for one item
  function automatic logic [31:0] atan2_angle(logic [31:0] yv, logic [31:0] xv);
    longint ay, ax, mn, mx, r, t, acc, base, mag;
    longint cf [5];
    logic neg;
    logic [31:0] a;
    begin
      cf[0] = 1073597943; cf[1] = -354656388; cf[2] = 193424926;
      cf[3] = -91410863; cf[4] = 22371518;
      ay = yv[31] ? (64'h1_0000_0000 - longint'(yv)) : longint'(yv);
      ax = xv[31] ? (64'h1_0000_0000 - longint'(xv)) : longint'(xv);
      neg = yv[31];
      if (ax == 0) begin
        mag = (ay == 0) ? 0 : 1686629713;
        if (ay == 0) neg = 1'b0;
      end else begin
        mn = (ay < ax) ? ay : ax;
        mx = (ay < ax) ? ax : ay;
        r = (mn << RFB) / mx;
        if (RFB >= 30) r = r >>> (RFB - 30);
        else r = r << (30 - RFB);
        t = (r * r) >>> 30;
        acc = cf[4];
        for (int i = 3; i >= 0; i--) acc = cf[i] + q30_product(acc, t);
        acc = q30_product(acc, r);
        base = (acc < 0) ? 0 : acc;
        if (ay > ax) base = (1686629713 > base) ? 1686629713 - base : 0;
        mag = xv[31] ? (64'd3373259426 - base) : base;
      end
      a = 32'(mag >> (30 - AFB));
      if (neg) a = -a;
      atan2_angle = a;
    end
  endfunction

  class angle_board;
    logic [31:0] pending [$];
    int errors;

    function void note_item(logic [31:0] yv, logic [31:0] xv);
      pending.push_back(atan2_angle(yv, xv));
    endfunction

    function void check_angle(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected angle %h", $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        if (want !== got) begin
          $display("%0t: angle expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_stall, res_valid, res_stall;
  logic [31:0] y_value, x_value, angle;
  int send_idle, recv_stall;
  angle_board board;

  arc_tangent_two_argument DUT (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .y_value(y_value), .x_value(x_value), .res_valid(res_valid),
    .res_stall(res_stall), .angle(angle)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_arc_tangent_two_argument NOT OK");
    $finish;
  end

  // Sample results at the rising edge
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_angle(angle);
  end

  // Drive receiver stall at the falling edge
  always @(negedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < recv_stall);
  end

  // Present one item; hold it until accepted
  task automatic send_item(logic [31:0] yv, logic [31:0] xv);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    y_value <= yv;
    x_value <= xv;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_item(yv, xv);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: pick_value = $urandom_range(15);
      1: pick_value = -$urandom_range(15);
      2: pick_value = {1'b1, 31'($urandom_range(3))};
      3: pick_value = $urandom >> $urandom_range(31);
      default: pick_value = $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] v;
    board = new();
    rst = 1'b1;
    req_valid = 1'b0;
    res_stall = 1'b0;
    y_value = '0;
    x_value = '0;
    send_idle = 0;
    recv_stall = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: axes, origin, diagonals, extremes
    send_item(32'd0, 32'd0);
    send_item(32'd5, 32'd0);
    send_item(-32'd5, 32'd0);
    send_item(32'd0, -32'd7);
    send_item(32'd0, 32'd7);
    send_item(32'd9, 32'd9);
    send_item(-32'd9, -32'd9);
    send_item(32'd9, -32'd9);
    send_item(32'h8000_0000, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'h8000_0000);
    send_item(32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h8000_0000, 32'd0);
    send_item(32'd0, 32'h8000_0000);
    send_item(32'd1, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'd1);
    send_item(-32'd1, 32'h8000_0000);
    send_item(32'hffff_ffff, 32'hffff_ffff);
    // Random phases with varying idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 64; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 64; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      for (int i = 0; i < NUM_RANDOM / 4; i++) begin
        v = pick_value();
        send_item(v, ($urandom_range(7) == 0) ? v : pick_value());
      end
    end
    // Drop valid once the last item has gone
    req_valid <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (RFB + 40) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_arc_tangent_two_argument OK");
    end else begin
      $display("tb_arc_tangent_two_argument NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/at2_pkg.sv
hdl/at2_front.sv
hdl/at2_queue.sv
hdl/at2_back.sv
hdl/arc_tangent_two_argument.sv
verif/tb_arc_tangent_two_argument.sv
